// ----- rtl/core/bfsp_pkg.sv -----
`default_nettype none
package bfsp_pkg;

  // fixed field widths of the channels
  localparam int VERTEX_W   = 5;
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_W     = 32;
  localparam int COUNT_W    = 6;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RESET  = 6'd32;
  localparam logic [VERTEX_W-1:0] SOURCE_VERTEX_RESET = 5'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT  = 2'd0,
    REG_SOURCE_VERTEX = 2'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- rtl/core/bfsp_if.sv -----
`default_nettype none
// edge request channel
interface bfsp_in_if;
  import bfsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VERTEX_W-1:0]    from_vertex;
  logic [VERTEX_W-1:0]    to_vertex;
  logic [WEIGHT_IN_W-1:0] edge_weight;
  logic                   last_edge;

  modport source (output valid, from_vertex, to_vertex, edge_weight, last_edge, input ready);
  modport sink   (input valid, from_vertex, to_vertex, edge_weight, last_edge, output ready);
endinterface

// per-vertex result channel
interface bfsp_out_if;
  import bfsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex_index;
  logic [DIST_W-1:0]   distance;
  logic                reachable;
  logic [VERTEX_W-1:0] predecessor;
  logic                negative_cycle;
  logic                edges_dropped;
  logic                last_result;

  modport source (output valid, vertex_index, distance, reachable, predecessor,
                  negative_cycle, edges_dropped, last_result, input ready);
  modport sink   (input valid, vertex_index, distance, reachable, predecessor,
                  negative_cycle, edges_dropped, last_result, output ready);
endinterface

// register write channel
interface bfsp_cfg_if;
  import bfsp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bellman_ford_shortest_paths.sv -----
`default_nettype none
// bellman-ford single-source shortest paths over a loaded edge list
//
// in_edge: one directed weighted edge per request; in_ready is high while the
//   block is loading, so edges are taken back to back. an edge naming a vertex not
//   below the vertex count, or arriving with the store full, is dropped and
//   flagged. the request with last_edge set starts the run, stored unless dropped.
// run: the init state seeds every vertex as its own predecessor and the source
//   distance, then n passes over the edge list (n-1 relaxation rounds and one check
//   pass). each edge goes through fetch and tail read, and when its tail is usable
//   also head read and relax, bound by the single read port of the distance memory
//   feeding the shared add/compare unit.
// out_result: n results, vertex 0 first, each through a read and a load state. the
//   result register holds while out_ready is low; after the final result is
//   loaded the block empties its edge store and accepts edges again even
//   while that result still waits.
// cfg_wr: always ready; registers must be written only while the block is idle, which
//   the block itself does not enforce. reset (rst_n low, synchronous): vertex count 32,
//   source 0, edge store empty, no result pending. no clearing pass is needed.
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  bfsp_in_if.sink     in_edge,
  bfsp_out_if.source  out_result,
  bfsp_cfg_if.sink    cfg_wr
);
  import bfsp_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_RDU,
    ST_RDV,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  // control state
  state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]      vcount_r, vcount_nxt;
  logic [VERTEX_W-1:0]     src_r, src_nxt;
  logic [ETW-1:0]          edge_total_r, edge_total_nxt;
  logic                    dropped_r, dropped_nxt;
  logic [ETW-1:0]          edge_idx_r, edge_idx_nxt;
  logic [NW-1:0]           pass_r, pass_nxt;
  logic [NW-1:0]           vidx_r, vidx_nxt;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;
  logic [MAX_VERTICES-1:0] mod_r, mod_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload
  logic signed [DIST_W-1:0] du_r, du_nxt;
  logic [VERTEX_W-1:0]      out_index_r, out_index_nxt;
  logic [DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic                     out_reach_r, out_reach_nxt;
  logic [VERTEX_W-1:0]      out_pred_r, out_pred_nxt;
  logic                     out_neg_r, out_neg_nxt;
  logic                     out_drop_r, out_drop_nxt;
  logic                     out_last_r, out_last_nxt;

  // vertex memories: distances, check-pass copy, predecessors
  logic [DIST_W-1:0] dist_main [MAX_VERTICES];
  logic [DIST_W-1:0] dist_chk  [MAX_VERTICES];
  logic [VIW-1:0]    pred_mem  [MAX_VERTICES];
  logic [DIST_W-1:0] main_q;
  logic [DIST_W-1:0] chk_q;
  logic [VIW-1:0]    pred_q;
  logic [VIW-1:0]    vaddr;
  logic              main_we;
  logic [VIW-1:0]    main_wa;
  logic [DIST_W-1:0] main_wd;
  logic              chk_we;
  logic              pred_we;
  logic [VIW-1:0]    pred_wa;
  logic [VIW-1:0]    pred_wd;

  // edge store
  logic                   edge_we;
  logic [VIW-1:0]         edge_tail_q;
  logic [VIW-1:0]         edge_head_q;
  logic [WEIGHT_BITS-1:0] edge_weight_q;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [DIST_W-1:0]      in_weight_ext;

  // shared relax unit
  logic signed [DIST_W-1:0] dv;
  logic                     head_reach;
  logic signed [DIST_W-1:0] cand;
  logic                     take;

  logic [NW-1:0] n_eff;
  logic          checking;
  logic          in_fire;
  logic          in_drop;
  logic          tail_ok;
  logic          out_free;
  logic          vidx_last;

  // effective vertex count: zero acts as one, clamp to capacity
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_r);
    end
  end

  assign checking  = (pass_r == n_eff - NW'(1));
  assign vidx_last = (vidx_r == n_eff - NW'(1));
  assign in_fire   = in_edge.valid && in_edge.ready;
  assign out_free  = !out_valid_r || out_result.ready;

  assign in_drop = !(32'(in_edge.from_vertex) < 32'(n_eff)) ||
                   !(32'(in_edge.to_vertex) < 32'(n_eff)) ||
                   (edge_total_r == ETW'(MAX_EDGES));

  // sign-extend the 16-bit field, then wrap to the stored weight width
  assign in_weight_ext = DIST_W'(signed'(in_edge.edge_weight));
  assign in_weight     = in_weight_ext[WEIGHT_BITS-1:0];
  assign edge_we       = in_fire && !in_drop;

  // tail usable: both ends in range and the tail already reached
  assign tail_ok = (32'(edge_tail_q) < 32'(n_eff)) && (32'(edge_head_q) < 32'(n_eff)) &&
                   (reach_r[edge_tail_q] || (checking && mod_r[edge_tail_q]));

  // the check pass reads its own copy where it has already changed a vertex
  assign dv         = (checking && mod_r[edge_head_q]) ? chk_q : main_q;
  assign head_reach = reach_r[edge_head_q] || (checking && mod_r[edge_head_q]);

  bfsp_edge_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_edge_store (
    .clk       (clk),
    .wr_en     (edge_we),
    .wr_addr   (edge_total_r[EAW-1:0]),
    .wr_tail   (VIW'(in_edge.from_vertex)),
    .wr_head   (VIW'(in_edge.to_vertex)),
    .wr_weight (in_weight),
    .rd_addr   (edge_idx_r[EAW-1:0]),
    .rd_tail   (edge_tail_q),
    .rd_head   (edge_head_q),
    .rd_weight (edge_weight_q)
  );

  bfsp_relax_unit #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_relax_unit (
    .tail_dist  (du_r),
    .weight     (edge_weight_q),
    .head_dist  (dv),
    .head_reach (head_reach),
    .cand       (cand),
    .take       (take)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    src_nxt        = src_r;
    edge_total_nxt = edge_total_r;
    dropped_nxt    = dropped_r;
    edge_idx_nxt   = edge_idx_r;
    pass_nxt       = pass_r;
    vidx_nxt       = vidx_r;
    reach_nxt      = reach_r;
    mod_nxt        = mod_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    du_nxt         = du_r;
    out_index_nxt  = out_index_r;
    out_dist_nxt   = out_dist_r;
    out_reach_nxt  = out_reach_r;
    out_pred_nxt   = out_pred_r;
    out_neg_nxt    = out_neg_r;
    out_drop_nxt   = out_drop_r;
    out_last_nxt   = out_last_r;
    vaddr          = vidx_r[VIW-1:0];
    main_we        = 1'b0;
    main_wa        = edge_head_q;
    main_wd        = cand;
    chk_we         = 1'b0;
    pred_we        = 1'b0;
    pred_wa        = vidx_r[VIW-1:0];
    pred_wd        = vidx_r[VIW-1:0];

    if (out_valid_r && out_result.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_drop) begin
            dropped_nxt = 1'b1;
          end else begin
            edge_total_nxt = edge_total_r + ETW'(1);
          end
          if (in_edge.last_edge) begin
            reach_nxt = '0;
            mod_nxt   = '0;
            neg_nxt   = 1'b0;
            vidx_nxt  = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // every vertex starts as its own predecessor
        pred_we = 1'b1;
        if (vidx_last) begin
          if (32'(src_r) < 32'(n_eff)) begin
            reach_nxt[VIW'(src_r)] = 1'b1;
            // source starts at distance zero
            main_we = 1'b1;
            main_wa = VIW'(src_r);
            main_wd = '0;
          end
          pass_nxt     = '0;
          edge_idx_nxt = '0;
          state_nxt    = ST_FETCH;
        end else begin
          vidx_nxt = vidx_r + NW'(1);
        end
      end
      ST_FETCH: begin
        if (edge_idx_r == edge_total_r) begin
          // end of pass
          edge_idx_nxt = '0;
          if (checking) begin
            vidx_nxt  = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            pass_nxt = pass_r + NW'(1);
          end
        end else begin
          state_nxt = ST_RDU;
        end
      end
      ST_RDU: begin
        vaddr = edge_tail_q;
        if (tail_ok) begin
          state_nxt = ST_RDV;
        end else begin
          edge_idx_nxt = edge_idx_r + ETW'(1);
          state_nxt    = ST_FETCH;
        end
      end
      ST_RDV: begin
        du_nxt    = (checking && mod_r[edge_tail_q]) ? chk_q : main_q;
        vaddr     = edge_head_q;
        state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        vaddr = edge_head_q;
        if (take) begin
          pred_we = 1'b1;
          pred_wa = edge_head_q;
          pred_wd = edge_tail_q;
          if (checking) begin
            chk_we                = 1'b1;
            mod_nxt[edge_head_q]  = 1'b1;
            neg_nxt               = 1'b1;
          end else begin
            main_we               = 1'b1;
            reach_nxt[edge_head_q] = 1'b1;
          end
        end
        edge_idx_nxt = edge_idx_r + ETW'(1);
        state_nxt    = ST_FETCH;
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        // read address stays on vidx so the read data holds while stalled
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = VERTEX_W'(vidx_r);
          out_reach_nxt = reach_r[vidx_r[VIW-1:0]];
          out_dist_nxt  = reach_r[vidx_r[VIW-1:0]] ? main_q : '0;
          out_pred_nxt  = VERTEX_W'(pred_q);
          out_neg_nxt   = neg_r;
          out_drop_nxt  = dropped_r;
          out_last_nxt  = vidx_last;
          if (vidx_last) begin
            edge_total_nxt = '0;
            dropped_nxt    = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            vidx_nxt  = vidx_r + NW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        REG_VERTEX_COUNT:  vcount_nxt = cfg_wr.data[COUNT_W-1:0];
        REG_SOURCE_VERTEX: src_nxt    = cfg_wr.data[VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vcount_r     <= VERTEX_COUNT_RESET;
      src_r        <= SOURCE_VERTEX_RESET;
      edge_total_r <= '0;
      dropped_r    <= 1'b0;
      edge_idx_r   <= '0;
      pass_r       <= '0;
      vidx_r       <= '0;
      reach_r      <= '0;
      mod_r        <= '0;
      neg_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      src_r        <= src_nxt;
      edge_total_r <= edge_total_nxt;
      dropped_r    <= dropped_nxt;
      edge_idx_r   <= edge_idx_nxt;
      pass_r       <= pass_nxt;
      vidx_r       <= vidx_nxt;
      reach_r      <= reach_nxt;
      mod_r        <= mod_nxt;
      neg_r        <= neg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    du_r        <= du_nxt;
    out_index_r <= out_index_nxt;
    out_dist_r  <= out_dist_nxt;
    out_reach_r <= out_reach_nxt;
    out_pred_r  <= out_pred_nxt;
    out_neg_r   <= out_neg_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  // vertex memories, registered reads from one read address shared by all three
  always_ff @(posedge clk) begin
    if (main_we) begin
      dist_main[main_wa] <= main_wd;
    end
    if (chk_we) begin
      dist_chk[edge_head_q] <= cand;
    end
    if (pred_we) begin
      pred_mem[pred_wa] <= pred_wd;
    end
    main_q <= dist_main[vaddr];
    chk_q  <= dist_chk[vaddr];
    pred_q <= pred_mem[vaddr];
  end

  // channel drive
  assign in_edge.ready             = (state_r == ST_IDLE);
  assign cfg_wr.ready              = 1'b1;
  assign out_result.valid          = out_valid_r;
  assign out_result.vertex_index   = out_index_r;
  assign out_result.distance       = out_dist_r;
  assign out_result.reachable      = out_reach_r;
  assign out_result.predecessor    = out_pred_r;
  assign out_result.negative_cycle = out_neg_r;
  assign out_result.edges_dropped  = out_drop_r;
  assign out_result.last_result    = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/core/bfsp_edge_store.sv -----
`default_nettype none
module bfsp_edge_store #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16,
  localparam int VIW = $clog2(MAX_VERTICES),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [EAW-1:0]         wr_addr,
  input  wire logic [VIW-1:0]         wr_tail,
  input  wire logic [VIW-1:0]         wr_head,
  input  wire logic [WEIGHT_BITS-1:0] wr_weight,
  input  wire logic [EAW-1:0]         rd_addr,
  output logic      [VIW-1:0]         rd_tail,
  output logic      [VIW-1:0]         rd_head,
  output logic      [WEIGHT_BITS-1:0] rd_weight
);
  import bfsp_pkg::*;

  localparam int WDEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int WAW    = $clog2(WDEPTH);

  logic [VIW-1:0]         tail_mem   [MAX_EDGES];
  logic [VIW-1:0]         head_mem   [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] weight_mem [WDEPTH];

  logic [WAW-1:0] wt_wr_addr;
  logic [WAW-1:0] wt_rd_addr;

  // row-major pair address, tail * MAX_VERTICES + head
  assign wt_wr_addr = WAW'(wr_tail) * WAW'(MAX_VERTICES) + WAW'(wr_head);
  assign wt_rd_addr = WAW'(rd_tail) * WAW'(MAX_VERTICES) + WAW'(rd_head);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail_mem[wr_addr]      <= wr_tail;
      head_mem[wr_addr]      <= wr_head;
      weight_mem[wt_wr_addr] <= wr_weight;
    end
    rd_tail   <= tail_mem[rd_addr];
    rd_head   <= head_mem[rd_addr];
    // follows the edge read, registered in the cycle after it
    rd_weight <= weight_mem[wt_rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/bfsp_relax_unit.sv -----
`default_nettype none
module bfsp_relax_unit #(
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic signed [bfsp_pkg::DIST_W-1:0] tail_dist,
  input  wire logic        [WEIGHT_BITS-1:0]      weight,
  input  wire logic signed [bfsp_pkg::DIST_W-1:0] head_dist,
  input  wire logic                               head_reach,
  output logic signed      [bfsp_pkg::DIST_W-1:0] cand,
  output logic                                    take
);
  import bfsp_pkg::*;

  logic signed [DIST_W:0] sum;
  logic signed [DIST_W:0] weight_ext;

  assign weight_ext = {{(DIST_W + 1 - WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
  assign sum = {tail_dist[DIST_W-1], tail_dist} + weight_ext;

  // saturate to the signed distance range
  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign take = !head_reach || (cand < head_dist);

endmodule
`default_nettype wire

// ----- rtl/core/bfsp_checker.sv -----
`default_nettype none
module bfsp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_last,
  input wire logic [bfsp_pkg::VERTEX_W-1:0] out_vertex_index,
  input wire logic [bfsp_pkg::DIST_W-1:0]   out_distance
);
  import bfsp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_index) && $stable(out_distance))
    else $error("result changed while stalled");

  // the final edge starts the run and closes the input
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("edge accepted right after final edge");

  // an ordinary edge keeps the block loading
  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("loading stopped without final edge");

  // no edge is taken while results of a run are still coming
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("edge accepted during result phase");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_edge.valid),
  .in_ready         (in_edge.ready),
  .in_last          (in_edge.last_edge),
  .out_valid        (out_result.valid),
  .out_ready        (out_result.ready),
  .out_last         (out_result.last_result),
  .out_vertex_index (out_result.vertex_index),
  .out_distance     (out_result.distance)
);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bfsp_pkg::*;

  // sizes of the block as instantiated (its default parameters)
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 256;

  // watchdog: cycles in a row with no handshake on any channel
  localparam int QUIET_LIMIT   = 100000;
  // long receiver hold-off used to back the block up into its edge input
  localparam int HOLD_CYCLES   = 600;
  // cycles granted after the last result before a register write
  localparam int SETTLE_CYCLES = 8;
  // edge requests per random traffic phase
  localparam int PHASE_ITEMS   = 25;
  // cap on printed mismatch lines, later ones are only counted
  localparam int MAX_REPORTS   = 100;

  localparam longint DIST_MAX = (64'sd1 <<< 31) - 1;
  localparam longint DIST_MIN = -(64'sd1 <<< 31);

  // one per-vertex result as the block should present it
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_index;
    logic [DIST_W-1:0]   distance;
    logic                reachable;
    logic [VERTEX_W-1:0] predecessor;
    logic                negative_cycle;
    logic                edges_dropped;
    logic                last_result;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  bfsp_in_if  edge_bus ();
  bfsp_out_if result_bus ();
  bfsp_cfg_if reg_bus ();

  // result ready comes from one register driven by the receiver process
  logic accept_results = 1'b0;
  assign result_bus.ready = accept_results;

  bellman_ford_shortest_paths dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_edge    (edge_bus),
    .out_result (result_bus),
    .cfg_wr     (reg_bus)
  );

  // ---------------------------------------------------------------------
  // shortest-path predictor: its own copy of registers and edge store
  // ---------------------------------------------------------------------
  logic [COUNT_W-1:0]         vertex_count_reg = VERTEX_COUNT_RESET;
  logic [VERTEX_W-1:0]        source_reg       = SOURCE_VERTEX_RESET;
  logic [VERTEX_W-1:0]        stored_tail [MAX_EDGES];
  logic [VERTEX_W-1:0]        stored_head [MAX_EDGES];
  // weight per (tail, head) pair; the latest load of a pair wins for every copy
  logic signed [WEIGHT_IN_W-1:0] pair_weight [MAX_VERTICES*MAX_VERTICES];
  int                         stored_edges = 0;
  bit                         drop_seen    = 1'b0;

  // working arrays of one run
  longint                     path_dist  [MAX_VERTICES];
  bit                         path_reach [MAX_VERTICES];
  logic [VERTEX_W-1:0]        path_pred  [MAX_VERTICES];

  // per-vertex results still owed by the block, oldest first
  vertex_result_t             pending_results [$];

  // run bookkeeping
  int  edges_sent     = 0;
  int  reg_writes     = 0;
  int  runs_solved    = 0;
  int  results_seen   = 0;
  int  mismatch_count = 0;

  // traffic shaping, set between phases by the test sequence
  int  send_idle_pct  = 0;
  int  stall_pct      = 0;
  int  hold_requests  = 0;

  // count 0 behaves as 1, anything above the store size as the store size
  function automatic int active_vertices();
    if (vertex_count_reg == 0) return 1;
    if (vertex_count_reg > MAX_VERTICES) return MAX_VERTICES;
    return int'(vertex_count_reg);
  endfunction

  // one pass over the stored edges in load order; edges touching a vertex
  // at or above n are skipped, unreachable tails never relax
  function automatic void relax_edges(input int n);
    int     u;
    int     v;
    longint cand;
    for (int e = 0; e < stored_edges; e++) begin
      u = int'(stored_tail[e]);
      v = int'(stored_head[e]);
      if (u >= n || v >= n || !path_reach[u]) continue;
      cand = path_dist[u] + longint'(pair_weight[u*MAX_VERTICES + v]);
      // saturate to the signed 32-bit distance range
      if (cand > DIST_MAX) cand = DIST_MAX;
      if (cand < DIST_MIN) cand = DIST_MIN;
      if (!path_reach[v] || cand < path_dist[v]) begin
        path_dist[v]  = cand;
        path_reach[v] = 1'b1;
        path_pred[v]  = VERTEX_W'(u);
      end
    end
  endfunction

  // full run: n-1 rounds, then the check pass. the check pass works on the
  // live arrays so predecessors pick up its updates, while the distances and
  // reach marks reported are the ones saved before it
  function automatic void solve_paths();
    int             n;
    bit             cycle_seen;
    longint         saved_dist  [MAX_VERTICES];
    bit             saved_reach [MAX_VERTICES];
    vertex_result_t res;
    n = active_vertices();
    for (int i = 0; i < n; i++) begin
      path_dist[i]  = 0;
      path_reach[i] = 1'b0;
      path_pred[i]  = VERTEX_W'(i);
    end
    // a source outside the graph leaves every vertex unreachable
    if (int'(source_reg) < n) path_reach[source_reg] = 1'b1;
    for (int round = 0; round + 1 < n; round++) relax_edges(n);
    saved_dist  = path_dist;
    saved_reach = path_reach;
    relax_edges(n);
    cycle_seen = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (path_reach[i] != saved_reach[i] ||
          (saved_reach[i] && path_dist[i] != saved_dist[i]))
        cycle_seen = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      res.vertex_index   = VERTEX_W'(i);
      res.distance       = saved_reach[i] ? DIST_W'(saved_dist[i]) : '0;
      res.reachable      = saved_reach[i];
      res.predecessor    = path_pred[i];
      res.negative_cycle = cycle_seen;
      res.edges_dropped  = drop_seen;
      res.last_result    = (i == n - 1);
      pending_results.insert(pending_results.size(), res);
    end
    // the store empties once the results are out
    stored_edges = 0;
    drop_seen    = 1'b0;
    runs_solved++;
  endfunction

  // an accepted edge request: store it or flag it, and solve on the last one
  function automatic void load_edge(input logic [VERTEX_W-1:0] from_v,
                                    input logic [VERTEX_W-1:0] to_v,
                                    input logic [WEIGHT_IN_W-1:0] weight,
                                    input bit last);
    int n;
    n = active_vertices();
    // the range check uses the vertex count at load time
    if (int'(from_v) >= n || int'(to_v) >= n || stored_edges >= MAX_EDGES) begin
      drop_seen = 1'b1;
    end else begin
      stored_tail[stored_edges] = from_v;
      stored_head[stored_edges] = to_v;
      // 16-bit weights pass unchanged at the block's weight width
      pair_weight[int'(from_v)*MAX_VERTICES + int'(to_v)] = weight;
      stored_edges++;
    end
    // the last edge starts the run even when it was dropped itself
    if (last) solve_paths();
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // offer one edge request, idling first at the current rate; valid stays up
  // after acceptance so back-to-back requests need no gap
  task automatic send_edge(input logic [VERTEX_W-1:0] from_v,
                           input logic [VERTEX_W-1:0] to_v,
                           input logic [WEIGHT_IN_W-1:0] weight,
                           input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      edge_bus.valid <= 1'b0;
      @(posedge clk);
    end
    edge_bus.valid       <= 1'b1;
    edge_bus.from_vertex <= from_v;
    edge_bus.to_vertex   <= to_v;
    edge_bus.edge_weight <= weight;
    edge_bus.last_edge   <= last;
    @(posedge clk);
    while (!edge_bus.ready) @(posedge clk);
    load_edge(from_v, to_v, weight, last);
    edges_sent++;
  endtask

  // drop valid after the last request of a burst
  task automatic stop_requests();
    edge_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every owed result has arrived, then let the block settle
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= value;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    reg_bus.valid <= 1'b0;
    case (idx)
      REG_VERTEX_COUNT:  vertex_count_reg = value;
      REG_SOURCE_VERTEX: source_reg       = value[VERTEX_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] count,
                           input logic [CFG_DATA_W-1:0] source);
    wait_idle();
    write_register(REG_VERTEX_COUNT, count);
    write_register(REG_SOURCE_VERTEX, source);
  endtask

  // ---------------------------------------------------------------------
  // result side: receiver ready and the per-result check
  // ---------------------------------------------------------------------

  // receiver: a requested hold-off is counted here, otherwise random stalls
  int hold_granted = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (hold_granted != hold_requests) begin
      hold_granted   <= hold_requests;
      hold_left      <= HOLD_CYCLES;
      accept_results <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      accept_results <= 1'b0;
    end else begin
      accept_results <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    vertex_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result for vertex %0d with none expected, expected none, got %0h",
                   $time, result_bus.vertex_index, result_bus.distance);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("vertex_index", 32'(want.vertex_index), 32'(result_bus.vertex_index));
        check_field("distance", want.distance, result_bus.distance);
        check_field("reachable", 32'(want.reachable), 32'(result_bus.reachable));
        check_field("predecessor", 32'(want.predecessor), 32'(result_bus.predecessor));
        check_field("negative_cycle", 32'(want.negative_cycle),
                    32'(result_bus.negative_cycle));
        check_field("edges_dropped", 32'(want.edges_dropped), 32'(result_bus.edges_dropped));
        check_field("last_result", 32'(want.last_result), 32'(result_bus.last_result));
      end
    end
  end

  // watchdog: a long run of cycles with no handshake anywhere means a hang
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (edge_bus.valid && edge_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (reg_bus.valid && reg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("bellman_ford_shortest_paths verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset values: 32 vertices from vertex 0; weight extremes and the top
  // vertex number on both ends of an edge
  task automatic test_reset_defaults();
    send_edge(5'd0, 5'd1, 16'h7FFF, 1'b0);
    send_edge(5'd1, 5'd2, 16'h8000, 1'b0);
    send_edge(5'd2, 5'd31, 16'h0001, 1'b0);
    send_edge(5'd31, 5'd30, 16'h5A5A, 1'b1);
    stop_requests();
  endtask

  // a pair loaded twice: both copies use the later weight
  task automatic test_duplicate_pair();
    configure(6'd4, 6'd0);
    send_edge(5'd0, 5'd1, 16'd5, 1'b0);
    send_edge(5'd1, 5'd2, 16'd3, 1'b0);
    send_edge(5'd0, 5'd1, 16'hFFFE, 1'b0);
    send_edge(5'd2, 5'd3, 16'd7, 1'b1);
    stop_requests();
  endtask

  // 1 -> 2 -> 1 sums to -2, the check pass still relaxes
  task automatic test_negative_cycle();
    configure(6'd3, 6'd0);
    send_edge(5'd0, 5'd1, 16'd1, 1'b0);
    send_edge(5'd1, 5'd2, 16'hFFFD, 1'b0);
    send_edge(5'd2, 5'd1, 16'd1, 1'b1);
    stop_requests();
  endtask

  // head or tail outside the graph: dropped and flagged, the run goes on
  task automatic test_dropped_edges();
    configure(6'd4, 6'd0);
    send_edge(5'd0, 5'd5, 16'd1, 1'b0);
    send_edge(5'd7, 5'd1, 16'd1, 1'b0);
    send_edge(5'd0, 5'd1, 16'd4, 1'b1);
    stop_requests();
  endtask

  // source outside the graph: nothing reachable, every vertex its own predecessor
  task automatic test_unreachable_source();
    configure(6'd4, 6'd9);
    send_edge(5'd0, 5'd1, 16'd3, 1'b0);
    send_edge(5'd1, 5'd2, 16'd3, 1'b1);
    stop_requests();
  endtask

  // count 0 acts as one vertex (a negative self loop still trips the check
  // pass), a count above the store size acts as the store size
  task automatic test_count_extremes();
    configure(6'd0, 6'd0);
    send_edge(5'd0, 5'd0, 16'hFFFF, 1'b1);
    stop_requests();
    configure(6'd63, 6'd31);
    send_edge(5'd31, 5'd0, 16'd100, 1'b0);
    send_edge(5'd0, 5'd31, 16'h8000, 1'b1);
    stop_requests();
  endtask

  // edges loaded at 8 vertices, count lowered to 4 before the last edge:
  // edges reaching vertex 5 and 6 sit in the store but are skipped
  task automatic test_count_lowered();
    configure(6'd8, 6'd0);
    send_edge(5'd0, 5'd5, 16'd2, 1'b0);
    send_edge(5'd5, 5'd6, 16'd2, 1'b0);
    send_edge(5'd0, 5'd1, 16'd2, 1'b0);
    stop_requests();
    wait_idle();
    write_register(REG_VERTEX_COUNT, 6'd4);
    send_edge(5'd1, 5'd2, 16'd3, 1'b1);
    stop_requests();
  endtask

  // fill the edge store on a two-vertex graph to keep the run short; the
  // request after that is dropped and carries last_edge
  task automatic test_store_full();
    configure(6'd2, 6'd0);
    for (int i = 0; i <= MAX_EDGES; i++)
      send_edge(VERTEX_W'($urandom_range(1)), VERTEX_W'($urandom_range(1)),
                16'($urandom_range(60)) - 16'd10, i == MAX_EDGES);
    stop_requests();
  endtask

  // receiver holds off while the next graph is already being offered: the
  // block backs up with a result waiting and keeps in_ready low
  task automatic test_output_backpressure();
    configure(6'd6, 6'd0);
    hold_requests++;
    send_edge(5'd0, 5'd1, 16'd3, 1'b0);
    send_edge(5'd1, 5'd2, 16'd4, 1'b0);
    send_edge(5'd2, 5'd3, 16'd1, 1'b0);
    send_edge(5'd3, 5'd4, 16'd2, 1'b0);
    send_edge(5'd4, 5'd5, 16'd6, 1'b1);
    send_edge(5'd0, 5'd2, 16'd1, 1'b0);
    send_edge(5'd2, 5'd5, 16'd1, 1'b0);
    send_edge(5'd5, 5'd4, 16'hFFFF, 1'b1);
    stop_requests();
  endtask

  // random graphs under four idling mixes; mostly well-formed edge lists,
  // a few out-of-range endpoints, counts and sources
  task automatic test_random_traffic();
    int                      idle_mix  [4] = '{0, 84, 0, 27};
    int                      stall_mix [4] = '{0, 0, 84, 27};
    int                      phase_edges;
    int                      n;
    int                      edge_total;
    logic [CFG_DATA_W-1:0]   count;
    logic [CFG_DATA_W-1:0]   source;
    logic [VERTEX_W-1:0]     from_v;
    logic [VERTEX_W-1:0]     to_v;
    logic [WEIGHT_IN_W-1:0]  weight;
    int                      pick;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      send_idle_pct = idle_mix[phase];
      stall_pct     = stall_mix[phase];
      phase_edges   = 0;
      while (phase_edges < PHASE_ITEMS) begin
        // mostly small graphs, now and then the full size or a count extreme
        pick = $urandom_range(99);
        if (pick < 70)      count = CFG_DATA_W'($urandom_range(10, 2));
        else if (pick < 85) count = CFG_DATA_W'($urandom_range(32, 11));
        else if (pick < 92) count = CFG_DATA_W'($urandom_range(63, 33));
        else                count = CFG_DATA_W'($urandom_range(1));
        if (count == 0)      n = 1;
        else if (count > 32) n = MAX_VERTICES;
        else                 n = int'(count);
        if ($urandom_range(99) < 85) source = CFG_DATA_W'($urandom_range(n - 1));
        else                         source = CFG_DATA_W'($urandom_range(63));
        configure(count, source);
        edge_total = $urandom_range(12, 1);
        for (int e = 0; e < edge_total; e++) begin
          if ($urandom_range(9) == 0) begin
            from_v = VERTEX_W'($urandom_range(31));
            to_v   = VERTEX_W'($urandom_range(31));
          end else begin
            from_v = VERTEX_W'($urandom_range(n - 1));
            to_v   = VERTEX_W'($urandom_range(n - 1));
          end
          // small weights make real paths, wide ones hit the sign bits
          pick = $urandom_range(9);
          if (pick < 6)      weight = 16'($urandom_range(48)) - 16'd12;
          else if (pick < 8) weight = 16'($urandom_range(1000));
          else               weight = 16'($urandom);
          send_edge(from_v, to_v, weight, e == edge_total - 1);
        end
        stop_requests();
        phase_edges += edge_total;
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    edge_bus.valid       <= 1'b0;
    edge_bus.from_vertex <= '0;
    edge_bus.to_vertex   <= '0;
    edge_bus.edge_weight <= '0;
    edge_bus.last_edge   <= 1'b0;
    reg_bus.valid        <= 1'b0;
    reg_bus.index        <= REG_VERTEX_COUNT;
    reg_bus.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_duplicate_pair();
    test_negative_cycle();
    test_dropped_edges();
    test_unreachable_source();
    test_count_extremes();
    test_count_lowered();
    test_store_full();
    test_output_backpressure();
    test_random_traffic();

    // drain, then give the block a little longer to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d edge requests and %0d register writes in %0d runs",
             edges_sent, reg_writes, runs_solved);
    $display("checked %0d vertex results, %0d field mismatches",
             results_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bellman_ford_shortest_paths verification clean");
    end else begin
      $display("bellman_ford_shortest_paths verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bfsp_pkg.sv
rtl/core/bfsp_if.sv
rtl/core/bfsp_edge_store.sv
rtl/core/bfsp_relax_unit.sv
rtl/core/bellman_ford_shortest_paths.sv
rtl/core/bfsp_checker.sv
test/testbench.sv
